[hw/rtl/key_value_line_parser_fnv1a_macros.svh]
// Assertion macros used by the line parser top level.
`ifndef KEY_VALUE_LINE_PARSER_FNV1A_MACROS_SVH
`define KEY_VALUE_LINE_PARSER_FNV1A_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KVLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define KVLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/kvlp_pkg.sv]
// Types, constants and helper functions of the key/value line parser.
package kvlp_pkg;

  localparam int OFFSET_W = 32;

  typedef logic [OFFSET_W-1:0] pos_t;
  typedef logic [63:0]         hash_t;

  localparam hash_t FNV_BASIS = 64'hcbf29ce484222325;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEP  = 8'h21;
  localparam logic [7:0] CH_SPC  = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0d;

  // Per-line parse state; cleared at every line end.
  typedef struct packed {
    logic  key_begun;
    logic  comment_line;
    pos_t  key_start;
    hash_t run_hash;
    hash_t hash_lns;
    pos_t  lns_pos;
    logic  sep_seen;
    logic  key_empty;
    hash_t hash_sep;
    pos_t  key_end;
    logic  val_begun;
    pos_t  val_start;
    pos_t  val_end;
  } kvlp_line_t;

  localparam kvlp_line_t LINE_CLEAR = '{
    key_begun:    1'b0,
    comment_line: 1'b0,
    key_start:    '0,
    run_hash:     FNV_BASIS,
    hash_lns:     FNV_BASIS,
    lns_pos:      '0,
    sep_seen:     1'b0,
    key_empty:    1'b0,
    hash_sep:     '0,
    key_end:      '0,
    val_begun:    1'b0,
    val_start:    '0,
    val_end:      '0
  };

  // One result; the last field sits in the lowest bits.
  typedef struct packed {
    logic [31:0] value_length;
    logic [31:0] value_pos;
    logic [31:0] key_length;
    logic [31:0] key_pos;
    hash_t       key_fnv;
  } kvlp_result_t;

  // Parser status seen by the top level checks.
  typedef struct packed {
    logic pos_zero;
    logic stopped;
  } kvlp_status_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPC) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // FNV-1a step. The prime is 2^40 + 0x1b3, so the product is a sum of shifts.
  function automatic hash_t fnv_step(input hash_t h, input logic [7:0] c);
    hash_t x;
    x = h ^ {56'd0, c};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

[hw/rtl/key_value_line_parser_fnv1a.sv]
// Top level of the key/value line parser with FNV-1a 64 key hashing.
//
//  channel | dir | payload (tdata, low bit up)                                  | side
//  in_     | in  | data_byte[7:0]                                               | tlast=last_byte
//  out_    | out | key_fnv[63:0] key_pos[95:64] key_length[127:96]              | -
//          |     | value_pos[159:128] value_length[191:160]                     |
//
// One byte request per cycle unless the output stalls; results leave via the output register.
// The rate is set by the FNV multiply-by-prime loop, one byte per cycle in the line state.
// Reset (rst_n low, synchronous) clears positions and the line state to the start of a file.
// A stalled result holds the output register; one more byte waits in the input register.
`include "key_value_line_parser_fnv1a_macros.svh"

module key_value_line_parser_fnv1a (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte[7:0]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata   // key_fnv, key_pos, key_length, value_pos, value_length
);

  logic                   advance;
  logic                   fire;
  logic [7:0]             byte_q;
  logic                   last_q;
  logic                   emit;
  kvlp_pkg::kvlp_result_t result;
  kvlp_pkg::kvlp_status_t status;

  kvlp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .advance   (advance),
    .fire      (fire),
    .byte_q    (byte_q),
    .last_q    (last_q)
  );

  kvlp_line_state u_line (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .byte_q (byte_q),
    .last_q (last_q),
    .emit   (emit),
    .result (result),
    .status (status)
  );

  kvlp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && emit),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `KVLP_ASSERT_NEXT(a_last_resets, fire && last_q, status.pos_zero && !status.stopped, "last byte did not reset the parser")
  `KVLP_ASSERT_NOW(a_no_emit_stopped, fire && status.stopped, !emit, "result produced after a zero byte")
  `KVLP_ASSERT_NEXT(a_emit_reaches_out, fire && emit, out_tvalid, "result was not registered")

endmodule

[hw/rtl/kvlp_in_stage.sv]
// Input register that holds one byte request until the parser takes it.
module kvlp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       advance,
  output logic       fire,
  output logic [7:0] byte_q,
  output logic       last_q
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       take;

  assign in_tready = !vld_r || advance;
  assign take      = in_tvalid && in_tready;
  assign fire      = vld_r && advance;
  assign byte_q    = byte_r;
  assign last_q    = last_r;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

endmodule

[hw/rtl/kvlp_line_state.sv]
// Line parser state, per-byte update and result decision.
module kvlp_line_state (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            byte_q,
  input  logic                  last_q,
  output logic                  emit,
  output kvlp_pkg::kvlp_result_t result,
  output kvlp_pkg::kvlp_status_t status
);

  kvlp_pkg::pos_t       pos_r;
  kvlp_pkg::pos_t       pos_nxt;
  logic                 stopped_r;
  logic                 stopped_nxt;
  kvlp_pkg::kvlp_line_t line_r;
  kvlp_pkg::kvlp_line_t line_nxt;
  kvlp_pkg::kvlp_line_t tk;
  kvlp_pkg::kvlp_line_t st;
  kvlp_pkg::hash_t      hash_upd;
  kvlp_pkg::pos_t       key_len;
  kvlp_pkg::pos_t       val_len;
  logic                 blank;
  logic                 sep;
  logic                 normal;
  logic                 line_end;

  assign blank    = kvlp_pkg::is_blank(byte_q);
  assign sep      = (byte_q == kvlp_pkg::CH_SEP);
  assign hash_upd = kvlp_pkg::fnv_step(line_r.run_hash, byte_q);
  assign normal   = !stopped_r && (byte_q != kvlp_pkg::CH_NUL) && (byte_q != kvlp_pkg::CH_NL);
  // The byte marked last closes the line as if a newline followed it.
  assign line_end = !stopped_r && (byte_q != kvlp_pkg::CH_NUL) &&
                    ((byte_q == kvlp_pkg::CH_NL) || last_q);

  // State after taking an ordinary byte.
  always_comb begin
    tk = line_r;
    if (sep) begin
      tk.sep_seen  = 1'b1;
      tk.key_empty = !line_r.key_begun;
      tk.hash_sep  = line_r.hash_lns;
      tk.key_end   = line_r.lns_pos;
      tk.val_begun = 1'b0;
      tk.val_start = '0;
      tk.val_end   = '0;
    end
    if (blank) begin
      if (line_r.key_begun) begin
        tk.run_hash = hash_upd;
      end
    end else begin
      if (!line_r.key_begun) begin
        tk.key_begun    = 1'b1;
        tk.key_start    = pos_r;
        tk.comment_line = (byte_q == kvlp_pkg::CH_HASH);
      end
      tk.run_hash = hash_upd;
      tk.hash_lns = hash_upd;
      tk.lns_pos  = pos_r;
      // Only a separator seen earlier on the line opens the value.
      if (line_r.sep_seen && !sep) begin
        if (!line_r.val_begun) begin
          tk.val_begun = 1'b1;
          tk.val_start = pos_r;
        end
        tk.val_end = pos_r;
      end
    end
  end

  assign st = normal ? tk : line_r;

  assign emit = line_end && st.sep_seen && !st.key_empty && !st.comment_line && st.val_begun;

  assign key_len = st.key_end - st.key_start + kvlp_pkg::pos_t'(1);
  assign val_len = st.val_end - st.val_start + kvlp_pkg::pos_t'(1);

  always_comb begin
    result.key_fnv      = st.hash_sep;
    result.key_pos      = 32'(st.key_start);
    result.key_length   = 32'(key_len);
    result.value_pos    = 32'(st.val_start);
    result.value_length = 32'(val_len);
  end

  always_comb begin
    pos_nxt     = pos_r;
    stopped_nxt = stopped_r;
    line_nxt    = line_r;
    if (fire) begin
      if (last_q) begin
        pos_nxt     = '0;
        stopped_nxt = 1'b0;
        line_nxt    = kvlp_pkg::LINE_CLEAR;
      end else if (!stopped_r) begin
        pos_nxt = pos_r + kvlp_pkg::pos_t'(1);
        if (byte_q == kvlp_pkg::CH_NUL) begin
          stopped_nxt = 1'b1;
        end else if (byte_q == kvlp_pkg::CH_NL) begin
          line_nxt = kvlp_pkg::LINE_CLEAR;
        end else begin
          line_nxt = tk;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      stopped_r <= 1'b0;
      line_r    <= kvlp_pkg::LINE_CLEAR;
    end else begin
      pos_r     <= pos_nxt;
      stopped_r <= stopped_nxt;
      line_r    <= line_nxt;
    end
  end

  assign status.pos_zero = (pos_r == '0);
  assign status.stopped  = stopped_r;

endmodule

[hw/rtl/kvlp_out_stage.sv]
// Result register on the output stream.
module kvlp_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  kvlp_pkg::kvlp_result_t result,
  output logic                   advance,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [191:0]           out_tdata
);

  logic                   vld_r;
  logic                   vld_nxt;
  kvlp_pkg::kvlp_result_t data_r;

  // The register is free when empty or when its request completes this cycle.
  assign advance    = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

[tb/tb_key_value_line_parser_fnv1a.sv]
// Self-checking testbench of the key/value line parser with FNV-1a 64 key hashing.
`timescale 1ns / 100ps

module tb_key_value_line_parser_fnv1a;

  localparam kvlp_pkg::hash_t FNV_PRIME    = 64'h00000100000001b3;
  localparam logic [7:0]      CH_VT        = 8'h0b;
  localparam logic [7:0]      CH_FF        = 8'h0c;
  localparam int              RUN_LIMIT    = 200000;
  localparam int              HOLD_CYCLES  = 300;
  localparam int              DRAIN_CYCLES = 8;

  // Parse state of the line in progress, kept by the predictor.
  typedef struct packed {
    logic            key_seen;
    logic            comment;
    kvlp_pkg::pos_t  key_first;
    kvlp_pkg::hash_t hash_run;
    kvlp_pkg::hash_t hash_solid;
    kvlp_pkg::pos_t  solid_pos;
    logic            have_sep;
    logic            key_missing;
    kvlp_pkg::hash_t hash_key;
    kvlp_pkg::pos_t  key_last;
    logic            val_seen;
    kvlp_pkg::pos_t  val_first;
    kvlp_pkg::pos_t  val_last;
  } line_track_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;

  int snd_idle_pct   = 0;
  int rcv_idle_pct   = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  line_track_t            ln;
  kvlp_pkg::pos_t         file_pos = '0;
  logic                   nul_hit  = 1'b0;
  kvlp_pkg::kvlp_result_t entries_due[$];
  logic [7:0]             byte_plan[$];

  key_value_line_parser_fnv1a i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("key_value_line_parser_fnv1a test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic blank_char(input logic [7:0] c);
    return (c == kvlp_pkg::CH_SPC) || (c >= kvlp_pkg::CH_TAB && c <= kvlp_pkg::CH_CR);
  endfunction

  function automatic kvlp_pkg::hash_t fnv1a(input kvlp_pkg::hash_t h, input logic [7:0] c);
    return (h ^ {56'd0, c}) * FNV_PRIME;
  endfunction

  function automatic line_track_t fresh_line();
    line_track_t t;
    t = '0;
    t.hash_run   = kvlp_pkg::FNV_BASIS;
    t.hash_solid = kvlp_pkg::FNV_BASIS;
    return t;
  endfunction

  function automatic logic finish_line();
    kvlp_pkg::kvlp_result_t r;
    logic                   kept;
    kept = ln.have_sep && !ln.key_missing && !ln.comment && ln.val_seen;
    if (kept) begin
      r.key_fnv      = ln.hash_key;
      r.key_pos      = ln.key_first;
      r.key_length   = kvlp_pkg::pos_t'(ln.key_last - ln.key_first + 1'b1);
      r.value_pos    = ln.val_first;
      r.value_length = kvlp_pkg::pos_t'(ln.val_last - ln.val_first + 1'b1);
      entries_due.insert(entries_due.size(), r);
    end
    ln = fresh_line();
    return kept;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    // Every separator restarts the value, so the last one on the line wins.
    if (c == kvlp_pkg::CH_SEP) begin
      ln.have_sep    = 1'b1;
      ln.key_missing = !ln.key_seen;
      ln.hash_key    = ln.hash_solid;
      ln.key_last    = ln.solid_pos;
      ln.val_seen    = 1'b0;
      ln.val_first   = '0;
      ln.val_last    = '0;
    end
    if (blank_char(c)) begin
      if (ln.key_seen) ln.hash_run = fnv1a(ln.hash_run, c);
    end else begin
      if (!ln.key_seen) begin
        ln.key_seen  = 1'b1;
        ln.key_first = file_pos;
        ln.comment   = (c == kvlp_pkg::CH_HASH);
      end
      ln.hash_run   = fnv1a(ln.hash_run, c);
      ln.hash_solid = ln.hash_run;
      ln.solid_pos  = file_pos;
      if (ln.have_sep && c != kvlp_pkg::CH_SEP) begin
        if (!ln.val_seen) begin
          ln.val_seen  = 1'b1;
          ln.val_first = file_pos;
        end
        ln.val_last = file_pos;
      end
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] c, input logic lst);
    logic emitted;
    emitted = 1'b0;
    if (!nul_hit) begin
      if (c == kvlp_pkg::CH_NUL) nul_hit = 1'b1;
      else if (c == kvlp_pkg::CH_NL) emitted = finish_line();
      else take_char(c);
      file_pos = file_pos + 1'b1;
    end
    // The last byte closes the file with an implicit newline.
    if (lst) begin
      if (!nul_hit && !emitted) void'(finish_line());
      file_pos = '0;
      nul_hit  = 1'b0;
      ln       = fresh_line();
    end
  endfunction

  // ------------------------------------------------------------ monitor/check

  always @(posedge clk) begin : monitor
    kvlp_pkg::kvlp_result_t seen;
    kvlp_pkg::kvlp_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (entries_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected entry: hash %h key %0d+%0d value %0d+%0d", seen.key_fnv,
                     seen.key_pos, seen.key_length, seen.value_pos, seen.value_length);
        end else begin
          want = entries_due.pop_front();
          if (seen.key_fnv !== want.key_fnv || seen.key_pos !== want.key_pos ||
              seen.key_length !== want.key_length || seen.value_pos !== want.value_pos ||
              seen.value_length !== want.value_length) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("entry mismatch (expected/actual): hash %h/%h key %0d+%0d/%0d+%0d",
                       want.key_fnv, seen.key_fnv, want.key_pos, want.key_length,
                       seen.key_pos, seen.key_length, " value %0d+%0d/%0d+%0d",
                       want.value_pos, want.value_length, seen.value_pos,
                       seen.value_length);
          end
        end
      end
    end
  end

  // The receiver stalls at random, or for a long stretch when a hold-off is pending.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic mark_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], mark_last && (i == s.len() - 1));
  endtask

  function automatic void plan_add(input logic [7:0] b);
    byte_plan.insert(byte_plan.size(), b);
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(4))
      0: return kvlp_pkg::CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      3: return kvlp_pkg::CH_CR;
      default: return kvlp_pkg::CH_SPC;
    endcase
  endfunction

  function automatic logic [7:0] rand_solid();
    logic [7:0] c;
    c = 8'($urandom_range(255, 1));
    while (blank_char(c) || c == kvlp_pkg::CH_SEP) c = 8'($urandom_range(255, 1));
    return c;
  endfunction

  function automatic void plan_blanks(input int max_n);
    repeat ($urandom_range(max_n)) plan_add(rand_blank());
  endfunction

  // A word starts with a solid byte and may hold inner blanks and, in keys, separators.
  function automatic void plan_word(input int max_len, input logic with_sep);
    int n;
    n = $urandom_range(max_len, 1);
    plan_add(rand_solid());
    for (int i = 1; i < n; i++) begin
      if ($urandom_range(5) == 0) plan_add(rand_blank());
      if (with_sep && $urandom_range(9) == 0) plan_add(kvlp_pkg::CH_SEP);
      else plan_add(rand_solid());
    end
  endfunction

  function automatic void plan_line();
    int kind;
    kind = $urandom_range(99);
    plan_blanks(2);
    if (kind < 70) begin
      plan_word(6, 1'b1);
      plan_blanks(2);
      plan_add(kvlp_pkg::CH_SEP);
      plan_blanks(2);
      plan_word(6, 1'b0);
      plan_blanks(2);
    end else if (kind < 78) begin
      plan_add(kvlp_pkg::CH_HASH);
      plan_word(4, 1'b0);
      plan_add(kvlp_pkg::CH_SEP);
      plan_word(4, 1'b0);
    end else if (kind < 84) begin
      plan_word(6, 1'b0);
    end else if (kind < 89) begin
      plan_add(kvlp_pkg::CH_SEP);
      plan_blanks(2);
      plan_word(4, 1'b0);
    end else if (kind < 94) begin
      plan_word(4, 1'b0);
      plan_blanks(2);
      plan_add(kvlp_pkg::CH_SEP);
      plan_blanks(2);
    end else begin
      repeat ($urandom_range(8, 1)) plan_add(8'($urandom_range(255, 1)));
    end
    plan_add(kvlp_pkg::CH_NL);
  endfunction

  task automatic test_trimmed_line();
    send_text(" a!b\t\n", 1'b0);
  endtask

  task automatic test_dropped_lines();
    send_text("#!c\n", 1'b0);
    send_text("!v\n", 1'b0);
    send_text("k! \n", 1'b0);
    send_text("q\n", 1'b0);
  endtask

  // Earlier separators belong to the key; the file ends without a newline.
  task automatic test_inner_separator();
    send_text("x!y!", 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_nul_stop();
    send_text("k!v", 1'b0);
    send_byte(kvlp_pkg::CH_NUL, 1'b0);
    send_byte("w", 1'b1);
    send_byte(kvlp_pkg::CH_NUL, 1'b1);
    send_text("k!v\n", 1'b1);
  endtask

  task automatic test_random_files(input int byte_goal);
    int sent;
    int ending;
    int cut;
    sent = 0;
    while (sent < byte_goal) begin
      byte_plan.delete();
      repeat ($urandom_range(6, 1)) plan_line();
      ending = $urandom_range(99);
      if (ending >= 45 && ending < 85) begin
        void'(byte_plan.pop_back());
      end else if (ending >= 85) begin
        // Stop the file on a zero byte, possibly followed by one ignored byte.
        cut = $urandom_range(byte_plan.size() - 1, 0);
        while (byte_plan.size() > cut) void'(byte_plan.pop_back());
        plan_add(kvlp_pkg::CH_NUL);
        if ($urandom_range(1)) plan_add(8'($urandom_range(255, 0)));
      end
      foreach (byte_plan[i]) send_byte(byte_plan[i], i == byte_plan.size() - 1);
      sent += byte_plan.size();
    end
  endtask

  // The receiver holds off while bytes keep coming, so the input side must stall.
  task automatic test_backpressure();
    snd_idle_pct = 0;
    hold_left    = HOLD_CYCLES;
    repeat (16) send_text(" key ! value\n", 1'b0);
    send_text("k!v", 1'b1);
  endtask

  initial begin
    ln = fresh_line();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 32;
    rcv_idle_pct = 88;
    test_trimmed_line();
    test_dropped_lines();
    test_inner_separator();
    test_nul_stop();
    test_random_files(500);

    snd_idle_pct = 88;
    rcv_idle_pct = 32;
    test_random_files(500);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_files(400);
    test_backpressure();

    in_tvalid <= 1'b0;
    while (entries_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && entries_due.size() == 0) begin
      $display("key_value_line_parser_fnv1a test passed");
    end else begin
      $display("key_value_line_parser_fnv1a test failed");
    end
    $finish;
  end

endmodule
